/* rtl/core/gbk_text_layout_defines.svh */
// Assertion helpers shared by the layout RTL.
`ifndef GBK_TEXT_LAYOUT_DEFINES_SVH
`define GBK_TEXT_LAYOUT_DEFINES_SVH

// same-cycle implication
`define GBK_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define GBK_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/gbk_pkg.sv */
package gbk_pkg;

   typedef enum logic [1:0] {
      CMD_ASCII = 2'd0,
      CMD_GLYPH = 2'd1,
      CMD_BLANK = 2'd2,
      CMD_END   = 2'd3
   } cmd_kind_type;

   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DATA_BITS = 24;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ORIGIN_X    = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ORIGIN_Y    = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BOX_WIDTH   = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BOX_HEIGHT  = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FONT_SIZE   = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_OVERLAY     = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] CSR_GLYPH_BASE  = 3'd6;

   localparam logic [7:0] BYTE_END       = 8'h00;
   localparam logic [7:0] BYTE_CR        = 8'd13;
   localparam logic [7:0] LEAD_THRESHOLD = 8'h80;
   localparam logic [7:0] LEAD_MIN       = 8'h81;
   localparam logic [7:0] BYTE_INVALID   = 8'hFF;
   localparam logic [7:0] TRAIL_MIN      = 8'h40;
   localparam logic [7:0] TRAIL_GAP      = 8'h7F;
   localparam logic [7:0] TRAIL_HIGH_OFS = 8'h41;
   localparam logic [7:0] HALF_LEAD      = 8'hA8;
   localparam logic [7:0] HALF_TRAIL_LO  = 8'hA1;
   localparam logic [7:0] HALF_TRAIL_HI  = 8'hB9;
   localparam logic [7:0] GLYPHS_PER_ROW = 8'd190;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS = 1;
   localparam int QCNT_BITS = 2;

   typedef struct packed {
      logic [15:0] origin_x;
      logic [15:0] origin_y;
      logic [15:0] box_width;
      logic [15:0] box_height;
      logic [1:0]  font_size_sel;
      logic        overlay_mode;
      logic [23:0] glyph_base_addr;
   } cfg_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [15:0]  pos_x;
      logic [15:0]  pos_y;
      logic [7:0]   code;
      logic [6:0]   row;
      logic [7:0]   col;
      logic [7:0]   nbytes;
   } job_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_INDEX,
      BK_SCALE,
      BK_SUM,
      BK_OUT
   } back_state_type;

   function automatic logic [5:0] font_height(input logic [1:0] sel);
      logic [5:0] h;
      case (sel)
         2'd0:    h = 6'd12;
         2'd1:    h = 6'd16;
         2'd2:    h = 6'd24;
         default: h = 6'd32;
      endcase
      return h;
   endfunction

   function automatic logic [7:0] glyph_len(input logic [1:0] sel);
      logic [7:0] n;
      case (sel)
         2'd0:    n = 8'd24;
         2'd1:    n = 8'd32;
         2'd2:    n = 8'd72;
         default: n = 8'd128;
      endcase
      return n;
   endfunction

endpackage

/* rtl/core/gbk_text_layout.sv */
// GBK text layout: takes one text byte per beat and emits at most one drawing command
// per byte (half-width ASCII, GBK glyph with flash address, blank glyph, or text end).
// The front end lays out the cursor and accepts a byte every cycle while its two-entry
// command queue has room; bytes that give no command (lead bytes, carriage return, the
// byte after it, bytes after the end) never occupy the queue. The back end turns each
// queued command into a response through its steps (queue pop, row index, glyph-size
// multiply, base add, output register) plus the wait for rsp_ready, and pops the next
// command only after the response is taken. Configuration must be written while idle.

module gbk_text_layout import gbk_pkg::*; #(
   parameter int COORD_BITS = 16,
   parameter int FLASH_ADDR_BITS = 24
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [7:0]               req_text_byte,
   input  logic                     req_first_of_string,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [1:0]               rsp_cmd_kind,
   output logic [15:0]              rsp_pos_x,
   output logic [15:0]              rsp_pos_y,
   output logic [7:0]               rsp_char_code,
   output logic [23:0]              rsp_glyph_addr,
   output logic [7:0]               rsp_glyph_bytes
);

   cfg_type cfg_ff;
   job_type push_job, pop_job;
   logic    push, pop, q_empty, q_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin_x        <= 16'd0;
         cfg_ff.origin_y        <= 16'd0;
         cfg_ff.box_width       <= 16'd240;
         cfg_ff.box_height      <= 16'd320;
         cfg_ff.font_size_sel   <= 2'd1;
         cfg_ff.overlay_mode    <= 1'b0;
         cfg_ff.glyph_base_addr <= 24'd0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_ORIGIN_X:   cfg_ff.origin_x        <= csr_wdata[15:0];
            CSR_ORIGIN_Y:   cfg_ff.origin_y        <= csr_wdata[15:0];
            CSR_BOX_WIDTH:  cfg_ff.box_width       <= csr_wdata[15:0];
            CSR_BOX_HEIGHT: cfg_ff.box_height      <= csr_wdata[15:0];
            CSR_FONT_SIZE:  cfg_ff.font_size_sel   <= csr_wdata[1:0];
            CSR_OVERLAY:    cfg_ff.overlay_mode    <= csr_wdata[0];
            CSR_GLYPH_BASE: cfg_ff.glyph_base_addr <= csr_wdata[23:0];
            default: ;
         endcase
      end
   end

   gbk_front #(
      .COORD_BITS(COORD_BITS)
   ) u_front (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg_ff),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_text_byte       (req_text_byte),
      .req_first_of_string (req_first_of_string),
      .queue_full          (q_full),
      .push                (push),
      .job                 (push_job)
   );

   gbk_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_job),
      .pop       (pop),
      .pop_data  (pop_job),
      .empty     (q_empty),
      .full      (q_full)
   );

   gbk_back #(
      .FLASH_ADDR_BITS(FLASH_ADDR_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .glyph_base_addr (cfg_ff.glyph_base_addr),
      .queue_empty     (q_empty),
      .queue_data      (pop_job),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_cmd_kind    (rsp_cmd_kind),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y),
      .rsp_char_code   (rsp_char_code),
      .rsp_glyph_addr  (rsp_glyph_addr),
      .rsp_glyph_bytes (rsp_glyph_bytes)
   );

endmodule

/* rtl/core/gbk_front.sv */
module gbk_front import gbk_pkg::*; #(
   parameter int COORD_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_text_byte,
   input  logic       req_first_of_string,
   input  logic       queue_full,
   output logic       push,
   output job_type    job
);

   localparam int CW = COORD_BITS;

   logic [CW-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [7:0]    lead_ff, lead_in;
   logic          pend_ff, pend_in, skip_ff, skip_in, done_ff, done_in;

   logic [CW-1:0] x0, y0, xw, yw;
   logic          pend0, skip0, done0;
   logic [5:0]    size, half, adv;
   logic [7:0]    nbytes, b;
   logic [17:0]   right_edge, bottom_edge;
   logic          wrap, ovf, accept, has_res, half_pair;

   assign req_ready = !queue_full;
   assign accept = req_valid && req_ready;
   assign push = accept && has_res;
   assign b = req_text_byte;

   always_comb begin
      size = font_height(cfg.font_size_sel);
      half = size >> 1;
      nbytes = glyph_len(cfg.font_size_sel);
      if (req_first_of_string) begin
         x0 = CW'(cfg.origin_x);
         y0 = CW'(cfg.origin_y);
         pend0 = 1'b0;
         skip0 = 1'b0;
         done0 = 1'b0;
      end else begin
         x0 = cur_x_ff;
         y0 = cur_y_ff;
         pend0 = pend_ff;
         skip0 = skip_ff;
         done0 = done_ff;
      end
      adv = pend0 ? size : half;
      right_edge = 18'(cfg.origin_x) + 18'(cfg.box_width);
      bottom_edge = 18'(cfg.origin_y) + 18'(cfg.box_height);
      wrap = (18'(x0) + 18'(adv)) > right_edge;
      xw = wrap ? CW'(cfg.origin_x) : x0;
      yw = wrap ? CW'(y0 + CW'(size)) : y0;
      ovf = (18'(yw) + 18'(size)) > bottom_edge;
      half_pair = (lead_ff == HALF_LEAD) && (b inside {[HALF_TRAIL_LO:HALF_TRAIL_HI]});

      cur_x_in = x0;
      cur_y_in = y0;
      lead_in = lead_ff;
      pend_in = pend0;
      skip_in = skip0;
      done_in = done0;
      has_res = 1'b0;
      job.kind = CMD_END;
      job.pos_x = 16'(xw);
      job.pos_y = 16'(yw);
      job.code = 8'd0;
      job.row = 7'(lead_ff - LEAD_MIN);
      job.col = (b < TRAIL_GAP) ? (b - TRAIL_MIN) : (b - TRAIL_HIGH_OFS);
      job.nbytes = 8'd0;

      if (!done0) begin
         if (b == BYTE_END) begin
            pend_in = 1'b0;
            skip_in = 1'b0;
            done_in = 1'b1;
            has_res = 1'b1;
            job.pos_x = 16'(x0);
            job.pos_y = 16'(y0);
         end else if (skip0) begin
            skip_in = 1'b0;
         end else if (!pend0) begin
            if (b > LEAD_THRESHOLD) begin
               lead_in = b;
               pend_in = 1'b1;
            end else begin
               cur_x_in = xw;
               cur_y_in = yw;
               if (ovf) begin
                  done_in = 1'b1;
                  has_res = 1'b1;
               end else if (b == BYTE_CR) begin
                  cur_y_in = CW'(yw + CW'(size));
                  cur_x_in = CW'(cfg.origin_x + 16'(half));
                  skip_in = 1'b1;
               end else begin
                  has_res = 1'b1;
                  job.kind = CMD_ASCII;
                  job.code = b;
                  cur_x_in = CW'(xw + CW'(half));
               end
            end
         end else begin
            pend_in = 1'b0;
            cur_x_in = xw;
            cur_y_in = yw;
            has_res = 1'b1;
            if (ovf) begin
               done_in = 1'b1;
            end else begin
               job.nbytes = nbytes;
               if (lead_ff == BYTE_INVALID || b < TRAIL_MIN || b == BYTE_INVALID) begin
                  job.kind = CMD_BLANK;
               end else begin
                  job.kind = CMD_GLYPH;
               end
               cur_x_in = half_pair ? CW'(xw + CW'(half)) : CW'(xw + CW'(size));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff <= '0;
         cur_y_ff <= '0;
         lead_ff  <= '0;
         pend_ff  <= 1'b0;
         skip_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else if (accept) begin
         cur_x_ff <= cur_x_in;
         cur_y_ff <= cur_y_in;
         lead_ff  <= lead_in;
         pend_ff  <= pend_in;
         skip_ff  <= skip_in;
         done_ff  <= done_in;
      end
   end

endmodule

/* rtl/core/gbk_fifo.sv */
`include "gbk_text_layout_defines.svh"

module gbk_fifo import gbk_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_data,
   input  logic    pop,
   output job_type pop_data,
   output logic    empty,
   output logic    full
);

   job_type              mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_BITS-1:0] count_ff;

   assign empty = (count_ff == '0);
   assign full = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign pop_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   `GBK_ASSERT_NOW(a_no_overflow, clock, reset, push && !pop, !full, "queue overflow")
   `GBK_ASSERT_NOW(a_no_underflow, clock, reset, pop, !empty, "queue underflow")
   `GBK_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= QCNT_BITS'(QUEUE_DEPTH), "queue count out of range")

endmodule

/* rtl/core/gbk_back.sv */
`include "gbk_text_layout_defines.svh"

module gbk_back import gbk_pkg::*; #(
   parameter int FLASH_ADDR_BITS = 24
) (
   input  logic         clock,
   input  logic         reset,
   input  logic [23:0]  glyph_base_addr,
   input  logic         queue_empty,
   input  job_type      queue_data,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [1:0]   rsp_cmd_kind,
   output logic [15:0]  rsp_pos_x,
   output logic [15:0]  rsp_pos_y,
   output logic [7:0]   rsp_char_code,
   output logic [23:0]  rsp_glyph_addr,
   output logic [7:0]   rsp_glyph_bytes
);

   back_state_type state_ff, state_in;
   job_type        job_ff;
   logic [14:0]    idx_ff;
   logic [21:0]    prod_ff;
   logic [23:0]    addr_ff, sum, masked;

   always_comb begin
      state_in = state_ff;
      pop = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (!queue_empty) begin
               pop = 1'b1;
               state_in = BK_INDEX;
            end
         end
         BK_INDEX: state_in = BK_SCALE;
         BK_SCALE: state_in = BK_SUM;
         BK_SUM:   state_in = BK_OUT;
         BK_OUT: begin
            if (rsp_ready) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      sum = glyph_base_addr + 24'(prod_ff);
      for (int i = 0; i < 24; i++) begin
         masked[i] = (i < FLASH_ADDR_BITS) ? sum[i] : 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         job_ff <= queue_data;
      end
      if (state_ff == BK_INDEX) begin
         idx_ff <= 15'(job_ff.row * GLYPHS_PER_ROW) + 15'(job_ff.col);
      end
      if (state_ff == BK_SCALE) begin
         prod_ff <= 22'(idx_ff * job_ff.nbytes);
      end
      if (state_ff == BK_SUM) begin
         addr_ff <= (job_ff.kind == CMD_GLYPH) ? masked : 24'd0;
      end
   end

   assign rsp_valid = (state_ff == BK_OUT);
   assign rsp_cmd_kind = job_ff.kind;
   assign rsp_pos_x = job_ff.pos_x;
   assign rsp_pos_y = job_ff.pos_y;
   assign rsp_char_code = job_ff.code;
   assign rsp_glyph_addr = addr_ff;
   assign rsp_glyph_bytes = job_ff.nbytes;

   `GBK_ASSERT_NOW(a_glyph_has_len, clock, reset, rsp_valid && (rsp_cmd_kind == CMD_GLYPH || rsp_cmd_kind == CMD_BLANK), rsp_glyph_bytes != 8'd0, "glyph command without length")
   `GBK_ASSERT_NOW(a_addr_only_glyph, clock, reset, rsp_valid && rsp_cmd_kind != CMD_GLYPH, rsp_glyph_addr == 24'd0, "address on non-glyph command")
   `GBK_ASSERT_NEXT(a_single_out, clock, reset, rsp_valid && rsp_ready, !rsp_valid, "output beat repeated")

endmodule

/* verif/gbk_text_layout_test.sv */
`timescale 1ns / 1ps

module gbk_text_layout_test import gbk_pkg::*; ();

   typedef struct packed {
      cmd_kind_type kind;
      logic [15:0]  pos_x;
      logic [15:0]  pos_y;
      logic [7:0]   code;
      logic [23:0]  addr;
      logic [7:0]   nbytes;
   } layout_cmd_type;

   class layout_scoreboard;
      layout_cmd_type expected_cmds[$];
      cfg_type     cfg;
      logic [15:0] cur_x;
      logic [15:0] cur_y;
      logic [7:0]  lead;
      bit          lead_pend;
      bit          skip_byte;
      bit          ended;
      int          mismatches;

      function new();
         cfg = '0;
         cfg.box_width = 16'd240;
         cfg.box_height = 16'd320;
         cfg.font_size_sel = 2'd1;
         cur_x = '0;
         cur_y = '0;
         lead = '0;
         lead_pend = 1'b0;
         skip_byte = 1'b0;
         ended = 1'b0;
         mismatches = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] val);
         case (idx)
            CSR_ORIGIN_X:   cfg.origin_x = val[15:0];
            CSR_ORIGIN_Y:   cfg.origin_y = val[15:0];
            CSR_BOX_WIDTH:  cfg.box_width = val[15:0];
            CSR_BOX_HEIGHT: cfg.box_height = val[15:0];
            CSR_FONT_SIZE:  cfg.font_size_sel = val[1:0];
            CSR_OVERLAY:    cfg.overlay_mode = val[0];
            CSR_GLYPH_BASE: cfg.glyph_base_addr = val[23:0];
            default: ;
         endcase
      endfunction

      // wrap at the right edge, then report whether the line passes the bottom
      function bit wrap_hits_bottom(int unsigned adv, int unsigned size);
         int unsigned right;
         int unsigned bottom;
         right = int'(cfg.origin_x) + int'(cfg.box_width);
         if (int'(cur_x) + adv > right) begin
            cur_y = cur_y + 16'(size);
            cur_x = cfg.origin_x;
         end
         bottom = int'(cfg.origin_y) + int'(cfg.box_height);
         return (int'(cur_y) + size > bottom);
      endfunction

      function void note_byte(logic [7:0] b, logic first);
         int unsigned size;
         int unsigned half;
         int unsigned nb;
         int unsigned row;
         int unsigned col;
         int unsigned advance;
         longint unsigned addr;
         layout_cmd_type c;
         bit emit;
         case (cfg.font_size_sel)
            2'd0: begin
               size = 12;
               nb = 24;
            end
            2'd1: begin
               size = 16;
               nb = 32;
            end
            2'd2: begin
               size = 24;
               nb = 72;
            end
            default: begin
               size = 32;
               nb = 128;
            end
         endcase
         half = size / 2;
         advance = 0;
         emit = 1'b0;
         c = '0;
         if (first) begin
            cur_x = cfg.origin_x;
            cur_y = cfg.origin_y;
            lead_pend = 1'b0;
            skip_byte = 1'b0;
            ended = 1'b0;
         end
         if (ended) return;
         if (b == BYTE_END) begin
            lead_pend = 1'b0;
            skip_byte = 1'b0;
            ended = 1'b1;
            c.kind = CMD_END;
            emit = 1'b1;
         end else if (skip_byte) begin
            skip_byte = 1'b0;
         end else if (!lead_pend) begin
            if (b > LEAD_THRESHOLD) begin
               lead = b;
               lead_pend = 1'b1;
            end else if (wrap_hits_bottom(half, size)) begin
               ended = 1'b1;
               c.kind = CMD_END;
               emit = 1'b1;
            end else if (b == BYTE_CR) begin
               cur_y = cur_y + 16'(size);
               cur_x = cfg.origin_x + 16'(half);
               skip_byte = 1'b1;
            end else begin
               c.kind = CMD_ASCII;
               c.code = b;
               emit = 1'b1;
               advance = half;
            end
         end else begin
            lead_pend = 1'b0;
            if (wrap_hits_bottom(size, size)) begin
               ended = 1'b1;
               c.kind = CMD_END;
            end else begin
               c.nbytes = 8'(nb);
               if (lead == BYTE_INVALID || b < TRAIL_MIN || b == BYTE_INVALID) begin
                  c.kind = CMD_BLANK;
               end else begin
                  col = (b < TRAIL_GAP) ? 32'(b) - 32'(TRAIL_MIN) :
                                          32'(b) - 32'(TRAIL_HIGH_OFS);
                  row = 32'(lead) - 32'(LEAD_MIN);
                  addr = 64'(cfg.glyph_base_addr) +
                         64'((32'(GLYPHS_PER_ROW) * row + col) * nb);
                  c.kind = CMD_GLYPH;
                  c.addr = addr[23:0];
               end
               if (lead == HALF_LEAD && b >= HALF_TRAIL_LO && b <= HALF_TRAIL_HI)
                  advance = half;
               else
                  advance = size;
            end
            emit = 1'b1;
         end
         if (emit) begin
            c.pos_x = cur_x;
            c.pos_y = cur_y;
            expected_cmds.push_back(c);
         end
         cur_x = cur_x + 16'(advance);
      endfunction

      function void check_cmd(layout_cmd_type got);
         layout_cmd_type want;
         if (expected_cmds.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected beat: kind=%0d x=%0d y=%0d code=%h addr=%h bytes=%0d",
                        got.kind, got.pos_x, got.pos_y, got.code, got.addr, got.nbytes);
            return;
         end
         want = expected_cmds.pop_front();
         if (want.kind !== got.kind || want.pos_x !== got.pos_x ||
             want.pos_y !== got.pos_y || want.code !== got.code ||
             want.addr !== got.addr || want.nbytes !== got.nbytes) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: exp kind=%0d x=%0d y=%0d code=%h addr=%h bytes=%0d",
                        want.kind, want.pos_x, want.pos_y, want.code, want.addr,
                        want.nbytes, "\n          got kind=%0d x=%0d y=%0d code=%h addr=%h",
                        got.kind, got.pos_x, got.pos_y, got.code, got.addr,
                        " bytes=%0d", got.nbytes);
         end
      endfunction

      function void flush_leftover();
         if (expected_cmds.size() != 0) begin
            mismatches += expected_cmds.size();
            $display("%0d expected commands never arrived", expected_cmds.size());
         end
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     csr_wr_en = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [7:0]               req_text_byte = '0;
   logic                     req_first_of_string = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [1:0]               rsp_cmd_kind;
   logic [15:0]              rsp_pos_x;
   logic [15:0]              rsp_pos_y;
   logic [7:0]               rsp_char_code;
   logic [23:0]              rsp_glyph_addr;
   logic [7:0]               rsp_glyph_bytes;

   layout_scoreboard sb;
   int tx_idle_pct = 8;
   int rx_idle_pct = 75;
   int hold_off_count = 0;
   int beats_sent = 0;

   gbk_text_layout u_dut (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_text_byte       (req_text_byte),
      .req_first_of_string (req_first_of_string),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_cmd_kind        (rsp_cmd_kind),
      .rsp_pos_x           (rsp_pos_x),
      .rsp_pos_y           (rsp_pos_y),
      .rsp_char_code       (rsp_char_code),
      .rsp_glyph_addr      (rsp_glyph_addr),
      .rsp_glyph_bytes     (rsp_glyph_bytes)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin : beat_monitor
      layout_cmd_type got;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got.kind = cmd_kind_type'(rsp_cmd_kind);
            got.pos_x = rsp_pos_x;
            got.pos_y = rsp_pos_y;
            got.code = rsp_char_code;
            got.addr = rsp_glyph_addr;
            got.nbytes = rsp_glyph_bytes;
            sb.check_cmd(got);
         end
         if (req_valid && req_ready)
            sb.note_byte(req_text_byte, req_first_of_string);
      end
   end

   // receiver: random stalls, plus a long hold-off on request
   initial begin : rsp_driver
      int hold_left;
      int seen;
      hold_left = 0;
      seen = 0;
      forever begin
         @(negedge clock);
         if (seen != hold_off_count) begin
            seen = hold_off_count;
            hold_left = 150;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   initial begin : watchdog
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

   task automatic send_byte(input logic [7:0] b, input logic first);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_text_byte <= b;
      req_first_of_string <= first;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      beats_sent++;
   endtask

   task automatic csr_write(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      sb.write_reg(idx, val);
      @(negedge clock);
   endtask

   task automatic program_layout(input logic [15:0] ox, input logic [15:0] oy,
                                 input logic [15:0] w, input logic [15:0] h,
                                 input logic [1:0] fs, input logic ov,
                                 input logic [23:0] base);
      csr_write(CSR_ORIGIN_X, 24'(ox));
      csr_write(CSR_ORIGIN_Y, 24'(oy));
      csr_write(CSR_BOX_WIDTH, 24'(w));
      csr_write(CSR_BOX_HEIGHT, 24'(h));
      csr_write(CSR_FONT_SIZE, 24'(fs));
      csr_write(CSR_OVERLAY, 24'(ov));
      csr_write(CSR_GLYPH_BASE, base);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic drain();
      int guard;
      req_valid <= 1'b0;
      guard = 0;
      while (sb.expected_cmds.size() != 0 && guard < 20000) begin
         @(negedge clock);
         guard++;
      end
      repeat (16) @(negedge clock);
   endtask

   task automatic send_text(input int n);
      logic [7:0] txt[$];
      int r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         if (r < 40) begin
            txt.push_back(8'($urandom_range(8'h7E, 8'h20)));
         end else if (r < 45) begin
            txt.push_back(8'($urandom_range(8'h80, 8'h01)));
         end else if (r < 75) begin
            txt.push_back(8'($urandom_range(8'hFE, LEAD_MIN)));
            txt.push_back(8'($urandom_range(8'hFE, TRAIL_MIN)));
         end else if (r < 80) begin
            txt.push_back(BYTE_CR);
         end else if (r < 85) begin
            txt.push_back(HALF_LEAD);
            txt.push_back(8'($urandom_range(HALF_TRAIL_HI + 1, HALF_TRAIL_LO)));
         end else if (r < 88) begin
            txt.push_back(BYTE_INVALID);
            txt.push_back(8'($urandom_range(8'hFF, 8'h01)));
         end else if (r < 92) begin
            txt.push_back(8'($urandom_range(8'hFE, LEAD_MIN)));
            txt.push_back(($urandom_range(3) == 0) ? BYTE_INVALID :
                          8'($urandom_range(8'h3F, 8'h01)));
         end else begin
            txt.push_back(8'($urandom_range(8'hFF, 8'h01)));
         end
      end
      if ($urandom_range(9) != 0) txt.push_back(BYTE_END);
      foreach (txt[k])
         send_byte(txt[k], (k == 0) ? ($urandom_range(19) != 0) : ($urandom_range(49) == 0));
   endtask

   initial begin : stimulus
      int phase;
      int start;
      logic [15:0] ox;
      logic [15:0] oy;
      logic [15:0] w;
      logic [15:0] h;
      sb = new();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset layout: ascii edges, CR skip, glyph edges, invalid codes, half-width pairs
      send_byte(8'h41, 1'b1);
      send_byte(8'h80, 1'b0);
      send_byte(BYTE_CR, 1'b0);
      send_byte(8'h78, 1'b0);
      send_byte(8'hB0, 1'b0);
      send_byte(8'hA1, 1'b0);
      send_byte(LEAD_MIN, 1'b0);
      send_byte(TRAIL_MIN, 1'b0);
      send_byte(8'hFE, 1'b0);
      send_byte(8'hFE, 1'b0);
      send_byte(LEAD_MIN, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(BYTE_INVALID, 1'b0);
      send_byte(8'h50, 1'b0);
      send_byte(8'h90, 1'b0);
      send_byte(8'h3F, 1'b0);
      send_byte(8'h90, 1'b0);
      send_byte(BYTE_INVALID, 1'b0);
      send_byte(HALF_LEAD, 1'b0);
      send_byte(HALF_TRAIL_LO, 1'b0);
      send_byte(HALF_LEAD, 1'b0);
      send_byte(HALF_TRAIL_HI + 8'd1, 1'b0);
      send_byte(8'hB0, 1'b0);
      send_byte(BYTE_END, 1'b0);
      send_byte(8'h43, 1'b0);
      send_byte(BYTE_CR, 1'b1);
      send_byte(BYTE_END, 1'b0);
      send_byte(8'h90, 1'b1);
      send_byte(BYTE_CR, 1'b0);
      send_byte(BYTE_END, 1'b1);
      drain();

      // tiny box: wrap then overflow, for ascii and for glyphs
      program_layout(16'd0, 16'd0, 16'd20, 16'd20, 2'd0, 1'b0, 24'd0);
      repeat (4) send_byte(8'h41, 1'b0);
      send_byte(8'h41, 1'b1);
      repeat (4) send_byte(8'h41, 1'b0);
      send_byte(8'hB0, 1'b1);
      send_byte(8'hA1, 1'b0);
      send_byte(8'hB0, 1'b0);
      send_byte(8'hA1, 1'b0);
      drain();

      // back-pressure: receiver holds off while the sender keeps streaming
      program_layout(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 2'd1, 1'b0, 24'd0);
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      hold_off_count++;
      send_byte(8'h61, 1'b1);
      repeat (40) send_byte(8'($urandom_range(8'h7E, 8'h20)), 1'b0);
      drain();

      for (phase = 0; phase < 12; phase++) begin
         tx_idle_pct = (phase < 4) ? 8 : (phase < 8) ? 75 : 0;
         rx_idle_pct = (phase < 4) ? 75 : (phase < 8) ? 8 : 0;
         if (phase == 0) begin
            program_layout(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2'd3, 1'b1, 24'hFFFFFF);
         end else if (phase == 1) begin
            program_layout(16'd0, 16'd0, 16'd0, 16'd0, 2'd0, 1'b0, 24'd0);
         end else begin
            ox = ($urandom_range(4) == 0) ? 16'($urandom_range(16'hFFFF, 16'hFF00)) :
                 16'($urandom_range(300));
            oy = ($urandom_range(4) == 0) ? 16'($urandom_range(16'hFFFF, 16'hFF00)) :
                 16'($urandom_range(300));
            w = ($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom_range(400, 10));
            h = ($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom_range(400, 10));
            program_layout(ox, oy, w, h, 2'($urandom_range(3)), 1'($urandom_range(1)),
                           24'($urandom()));
         end
         start = beats_sent;
         while (beats_sent - start < 105) send_text($urandom_range(30, 3));
         drain();
      end

      sb.flush_leftover();
      if (sb.mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/gbk_pkg.sv
rtl/core/gbk_front.sv
rtl/core/gbk_fifo.sv
rtl/core/gbk_back.sv
rtl/core/gbk_text_layout.sv
verif/gbk_text_layout_test.sv
